/* hdl/npm_pkg.sv */
// Shared types and constants for the non-overlapping pattern matcher.
// No dependencies; every other file of the block imports this package.
package npm_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int POS_BITS    = 16;
    localparam int BYTE_W      = 8;
    localparam int CFG_W       = 64;
    localparam int CFG_BYTES   = 16;
    localparam int CFG_SEL_W   = 4;
    localparam int LEN_W       = 5;
    localparam int IDX_W       = 16;
    localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
    localparam int REG_IDX_W   = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PAT_LO  = 2'd0,
        REG_PAT_HI  = 2'd1,
        REG_PAT_LEN = 2'd2
    } t_reg_idx;

    // Per-cell shift control: advance the window, load zero instead of neighbor byte
    typedef struct packed {
        logic shift;
        logic zero;
    } t_cell_ctl;

    typedef struct packed {
        logic             match_end;
        logic [IDX_W-1:0] match_start;
        logic [IDX_W-1:0] byte_index;
        logic             found_any;
        logic             string_done;
    } t_result;

endpackage

/* hdl/npm_if.sv */
// Valid/ready channels of the pattern matcher: text request in, result request out.
// Depends on npm_pkg for field widths.
interface npm_in_if;
    import npm_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              first_byte;
    logic              last_byte;

    modport source (output valid, output text_byte, output first_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input text_byte, input first_byte, input last_byte,
                    output ready);
endinterface

interface npm_out_if;
    import npm_pkg::*;
    logic             valid;
    logic             ready;
    logic             match_end;
    logic [IDX_W-1:0] match_start;
    logic [IDX_W-1:0] byte_index;
    logic             found_any;
    logic             string_done;

    modport source (output valid, output match_end, output match_start, output byte_index,
                    output found_any, output string_done, input ready);
    modport sink   (input valid, input match_end, input match_start, input byte_index,
                    input found_any, input string_done, output ready);
endinterface

/* hdl/npm_cell.sv */
// One window cell: holds one text byte, passes it to the next cell on each shift
// and compares the byte it takes in against its aligned pattern byte. Uses npm_pkg.
module npm_cell (
    input  logic                      i_clk,
    input  npm_pkg::t_cell_ctl        i_ctl,
    input  logic [npm_pkg::BYTE_W-1:0] i_byte,
    input  logic [npm_pkg::BYTE_W-1:0] i_pat,
    input  logic                      i_active,
    output logic [npm_pkg::BYTE_W-1:0] o_byte,
    output logic                      o_eq
);
    import npm_pkg::*;

    logic [BYTE_W-1:0] w_byte;
    logic [BYTE_W-1:0] r_byte;

    assign w_byte = i_ctl.zero ? '0 : i_byte;
    // cells beyond the pattern length always agree
    assign o_eq   = !i_active || (w_byte == i_pat);
    assign o_byte = r_byte;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_byte <= w_byte;
        end
    end

endmodule

/* hdl/npm_out_buf.sv */
// Two-entry output buffer for result requests: an output register plus a skid entry.
// Depends on npm_pkg (t_result) and npm_out_if.
module npm_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  npm_pkg::t_result i_data,
    output logic             o_ready,
    npm_out_if.source        o_out
);
    import npm_pkg::*;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    w_pop;

    assign w_pop   = r_out_valid && o_out.ready;
    assign o_ready = !r_skid_valid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (w_pop || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = i_push;
                n_skid       = i_data;
            end else begin
                n_out       = i_data;
                n_out_valid = i_push;
            end
        end else if (i_push) begin
            // hold the output, park the new request
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.match_end   = r_out.match_end;
    assign o_out.match_start = r_out.match_start;
    assign o_out.byte_index  = r_out.byte_index;
    assign o_out.found_any   = r_out.found_any;
    assign o_out.string_done = r_out.string_done;

endmodule

/* hdl/nonoverlap_pattern_matcher_unit.sv */
// Non-overlapping pattern matcher: finds leftmost, non-overlapping occurrences of a
// 1 to 16 byte pattern in a byte stream. Depends on npm_pkg, npm_if, npm_cell, npm_out_buf.
//
// One text byte is taken per clock cycle while input ready is high, and each byte yields
// one result, registered in the output buffer. The text window is a row of 16 shift cells,
// each comparing its new byte against the pattern byte aligned to it, so the whole match
// decision and the restart counter update close in the acceptance cycle. A two-entry output
// buffer lets the next byte enter while a result is still waiting to be taken; input ready
// drops only when both entries are full. Write the pattern registers only while the block
// is idle. A byte with first_byte set clears position, restart count and found flag.
module nonoverlap_pattern_matcher_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [npm_pkg::REG_IDX_W-1:0]  i_cfg_idx,
    input  logic [npm_pkg::CFG_W-1:0]      i_cfg_data,
    npm_in_if.sink                         i_in,
    npm_out_if.source                      o_out
);
    import npm_pkg::*;

    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    // configuration
    logic [CFG_W-1:0] r_pat_lo;
    logic [CFG_W-1:0] r_pat_hi;
    logic [LEN_W-1:0] r_pat_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= LEN_W'(1);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_PAT_LO:  r_pat_lo  <= i_cfg_data;
                REG_PAT_HI:  r_pat_hi  <= i_cfg_data;
                REG_PAT_LEN: r_pat_len <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    logic [LEN_W-1:0]  w_len;
    logic [BYTE_W-1:0] w_pat_bytes [CFG_BYTES];

    always_comb begin
        if (r_pat_len == '0) begin
            w_len = LEN_W'(1);
        end else if (r_pat_len > LEN_W'(MAX_PATTERN)) begin
            w_len = LEN_W'(MAX_PATTERN);
        end else begin
            w_len = r_pat_len;
        end
    end

    always_comb begin
        for (int k = 0; k < CFG_BYTES / 2; k++) begin
            w_pat_bytes[k]                 = r_pat_lo[k*BYTE_W +: BYTE_W];
            w_pat_bytes[k + CFG_BYTES / 2] = r_pat_hi[k*BYTE_W +: BYTE_W];
        end
    end

    // acceptance and per-string tracking
    logic w_push;
    logic w_buf_ready;
    logic w_accept;

    assign i_in.ready = w_buf_ready;
    assign w_accept   = i_in.valid && w_buf_ready;

    // window cells: cell 0 holds the newest byte
    t_cell_ctl         w_ctl      [MAX_PATTERN];
    logic [BYTE_W-1:0] w_cell_in  [MAX_PATTERN];
    logic [BYTE_W-1:0] w_cell_out [MAX_PATTERN];
    logic [BYTE_W-1:0] w_cell_pat [MAX_PATTERN];
    logic              w_cell_act [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] w_eq;

    genvar g;
    generate
        for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
            logic [LEN_W-1:0] w_sel;

            assign w_sel         = LEN_W'(w_len - LEN_W'(1) - LEN_W'(g));
            assign w_cell_act[g] = LEN_W'(g) < w_len;
            assign w_cell_pat[g] = w_pat_bytes[w_sel[CFG_SEL_W-1:0]];
            assign w_ctl[g].shift = w_accept;

            if (g == 0) begin : g_head
                assign w_cell_in[g]  = i_in.text_byte;
                assign w_ctl[g].zero = 1'b0;
            end else begin : g_body
                assign w_cell_in[g]  = w_cell_out[g-1];
                assign w_ctl[g].zero = i_in.first_byte;
            end

            npm_cell u_cell (
                .i_clk    (i_clk),
                .i_ctl    (w_ctl[g]),
                .i_byte   (w_cell_in[g]),
                .i_pat    (w_cell_pat[g]),
                .i_active (w_cell_act[g]),
                .o_byte   (w_cell_out[g]),
                .o_eq     (w_eq[g])
            );
        end
    endgenerate

    logic [CNT_W-1:0]    r_count, n_count;
    logic [POS_BITS-1:0] r_pos, n_pos;
    logic                r_seen, n_seen;
    logic [CNT_W-1:0]    w_cnt_base, w_cnt_inc;
    logic [POS_BITS-1:0] w_idx;
    logic                w_hit;
    t_result             w_res;

    always_comb begin
        w_cnt_base = i_in.first_byte ? '0 : r_count;
        w_idx      = i_in.first_byte ? '0 : r_pos;
        w_cnt_inc  = (w_cnt_base < CNT_W'(MAX_PATTERN)) ? CNT_W'(w_cnt_base + CNT_W'(1))
                                                        : w_cnt_base;
        w_hit      = w_accept && (LEN_W'(w_cnt_inc) >= w_len) && (&w_eq);
        n_count    = w_hit ? '0 : w_cnt_inc;
        n_pos      = (w_idx < POS_MAX) ? POS_BITS'(w_idx + POS_BITS'(1)) : w_idx;
        n_seen     = (i_in.first_byte ? 1'b0 : r_seen) | w_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pos   <= '0;
            r_seen  <= 1'b0;
        end else if (w_accept) begin
            r_count <= n_count;
            r_pos   <= n_pos;
            r_seen  <= n_seen;
        end
    end

    always_comb begin
        w_res.match_end   = w_hit;
        w_res.match_start = w_hit ? IDX_W'(w_idx - POS_BITS'(w_len - LEN_W'(1))) : '0;
        w_res.byte_index  = IDX_W'(w_idx);
        w_res.found_any   = n_seen;
        w_res.string_done = i_in.last_byte;
    end

    assign w_push = w_accept;

    npm_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .o_ready (w_buf_ready),
        .o_out   (o_out)
    );

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_PATTERN))
        else $error("restart count beyond window");

    a_hit_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hit |=> (r_count == '0) && r_seen)
        else $error("match did not restart the scan");

    a_match_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.match_end) |-> o_out.found_any)
        else $error("match without found flag");

    a_no_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.match_end) |-> (o_out.match_start == '0))
        else $error("start index without match");

    a_hit_needs_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hit |-> (LEN_W'(w_cnt_inc) >= w_len) && w_accept)
        else $error("match with too few bytes since restart");

endmodule
